// ===== hw/rtl/sorted_stream_merge_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for sorted_stream_merge
// Concurrent checks sampled on clk_i and quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_STREAM_MERGE_MACROS_SVH
`define SORTED_STREAM_MERGE_MACROS_SVH

// Same-cycle implication.
`define SSM_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ssm_pkg.sv =====
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types and constants of the sorted stream merge.
// ----------------------------------------------------------------------------
`default_nettype none

package ssm_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned LenW    = 24;
  localparam int unsigned CfgIdxW = 1;

  localparam logic LIST_A = 1'b0;
  localparam logic LIST_B = 1'b1;

  localparam logic [CfgIdxW-1:0] REG_LENGTH_A = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_LENGTH_B = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_DONE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ERR,
    ST_RD,
    ST_CMP
  } state_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic restart;
  } list_cmd_t;

  typedef struct packed {
    logic nonempty;
    logic last_one;
    logic full;
    logic done;
  } list_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ssm_in_if.sv =====
// ----------------------------------------------------------------------------
// ssm_in_if
// Input element channel: one tagged element per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssm_in_if import ssm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic signed [DataW-1:0] value;

  modport source (output valid, mode, value, input ready);
  modport sink   (input valid, mode, value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ssm_out_if.sv =====
// ----------------------------------------------------------------------------
// ssm_out_if
// Result channel: merged elements and drop reports.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssm_out_if import ssm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] merged_value;
  logic                    from_list;
  logic                    run_last;
  logic                    merge_last;
  logic [1:0]              status;

  modport source (output valid, merged_value, from_list, run_last, merge_last, status,
                  input ready);
  modport sink   (input valid, merged_value, from_list, run_last, merge_last, status,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ssm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ssm_cfg_if
// Register write channel: index and data per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssm_cfg_if import ssm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [LenW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ssm_ram.sv =====
// ----------------------------------------------------------------------------
// ssm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ssm_list_state.sv =====
// ----------------------------------------------------------------------------
// ssm_list_state
// Bookkeeping of one list: length register, FIFO pointers, receive count.
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_list_state import ssm_pkg::*; #(
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     len_we_i,
  input  wire logic [LenW-1:0]          len_i,
  input  wire list_cmd_t                cmd_i,
  output logic      [$clog2(Depth)-1:0] head_o,
  output logic      [$clog2(Depth)-1:0] tail_o,
  output list_stat_t                    stat_o
);

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned FillW = $clog2(Depth + 1);
  localparam int unsigned SumW  = FillW + 1;

  logic [LenW-1:0]  len_q;
  logic [LenW-1:0]  recv_q, recv_d;
  logic [AddrW-1:0] head_q, head_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [SumW-1:0]  tail_sum;

  // The tail index stays below twice the depth, so one subtract wraps it.
  assign tail_sum = SumW'(head_q) + SumW'(fill_q);
  assign tail_o   = (tail_sum >= SumW'(Depth)) ? AddrW'(tail_sum - SumW'(Depth))
                                               : AddrW'(tail_sum);
  assign head_o   = head_q;

  assign stat_o.nonempty = (fill_q != '0);
  assign stat_o.last_one = (fill_q == FillW'(1));
  assign stat_o.full     = (fill_q == FillW'(Depth));
  assign stat_o.done     = (recv_q >= len_q);

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    recv_d = recv_q;
    if (cmd_i.push) begin
      fill_d = fill_q + 1'b1;
      recv_d = recv_q + 1'b1;
    end
    if (cmd_i.pop) begin
      head_d = (head_q == AddrW'(Depth - 1)) ? '0 : head_q + 1'b1;
      fill_d = fill_q - 1'b1;
    end
    if (cmd_i.restart) begin
      recv_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LenW'(1);
      recv_q <= '0;
      head_q <= '0;
      fill_q <= '0;
    end else begin
      if (len_we_i) begin
        len_q <= len_i;
      end
      recv_q <= recv_d;
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_stream_merge.sv =====
// ----------------------------------------------------------------------------
// sorted_stream_merge
// Two-way merge of two ascending lists of signed 32-bit values.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_i sets length_a (index 0) and length_b (index 1); write them while
//   the block is idle. in_i takes one element per request, tagged by mode
//   with its list, and stores it in that list's FIFO RAM. out_o returns the
//   merged ascending stream; list A wins ties. An element for a list that is
//   already complete, or whose FIFO is full, is dropped and reported by one
//   result with a nonzero status and a zero value.
//   Each input request yields zero or more results; run_last marks the last
//   one, merge_last marks the final element of the whole job.
// Timing:
//   A request is taken in the idle state. A drop report is then loaded in
//   the error state. Each merged element then passes the read state, in
//   which the RAM reads both FIFO heads, and the compare state, which
//   compares them and loads the output register. Once the last result sits
//   in the output register the next request is taken.
// Reset clears pointers, counts and the output valid flag, and sets both
// lengths to 1. A stalled receiver holds the output register and the
// sequencer waits; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_stream_merge_macros.svh"

module sorted_stream_merge import ssm_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ssm_cfg_if.sink    cfg_i,
  ssm_in_if.sink     in_i,
  ssm_out_if.source  out_o
);

  localparam int unsigned AddrW = $clog2(FIFO_DEPTH);

  state_e state_q, state_d;

  list_cmd_t  cmd_a, cmd_b;
  list_stat_t stat_a, stat_b, in_stat;
  logic [AddrW-1:0] head_a, tail_a, head_b, tail_b;
  logic [DataW-1:0] rdata_a, rdata_b;

  logic    cfg_we, in_acc, in_err;
  status_e in_code;
  status_e err_code_q;
  logic    err_mode_q;

  logic can_emit, pick, ne_a_nx, ne_b_nx, mlast, can_next, out_free;

  logic             load_en, load_run_last;
  logic [DataW-1:0] load_value;
  logic             load_list, load_mlast;
  status_e          load_status;

  logic             out_valid_q;
  logic [DataW-1:0] out_value_q;
  logic             out_list_q, out_run_last_q, out_mlast_q;
  status_e          out_status_q;

  // Configuration port.
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  // Request decode.
  assign in_acc  = in_i.valid && in_i.ready;
  assign in_stat = (in_i.mode == LIST_B) ? stat_b : stat_a;
  assign in_err  = in_stat.done || in_stat.full;
  assign in_code = in_stat.done ? STATUS_DONE : STATUS_FULL;

  // A head may leave when both FIFOs hold data, or when the other list is done.
  assign can_emit = (stat_a.nonempty && stat_b.nonempty) ||
                    (stat_a.nonempty && stat_b.done) ||
                    (stat_b.nonempty && stat_a.done);

  always_comb begin
    if (stat_a.nonempty && stat_b.nonempty) begin
      pick = ($signed(rdata_a) <= $signed(rdata_b)) ? LIST_A : LIST_B;
    end else if (stat_a.nonempty && stat_b.done) begin
      pick = LIST_A;
    end else begin
      pick = LIST_B;
    end
  end

  // Occupancy after the pop decides the job end and whether more can follow.
  assign ne_a_nx  = (pick == LIST_A) ? !stat_a.last_one : stat_a.nonempty;
  assign ne_b_nx  = (pick == LIST_B) ? !stat_b.last_one : stat_b.nonempty;
  assign mlast    = stat_a.done && stat_b.done && !ne_a_nx && !ne_b_nx;
  assign can_next = !mlast && ((ne_a_nx && ne_b_nx) || (ne_a_nx && stat_b.done) ||
                               (ne_b_nx && stat_a.done));

  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = in_err ? ST_ERR : ST_RD;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          state_d = can_emit ? ST_RD : ST_IDLE;
        end
      end
      ST_RD: begin
        state_d = can_emit ? ST_CMP : ST_IDLE;
      end
      ST_CMP: begin
        if (out_free) begin
          state_d = can_next ? ST_RD : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_i.ready    = 1'b0;
    cmd_a         = '0;
    cmd_b         = '0;
    load_en       = 1'b0;
    load_value    = '0;
    load_list     = err_mode_q;
    load_run_last = 1'b0;
    load_mlast    = 1'b0;
    load_status   = STATUS_OK;
    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        cmd_a.push = in_acc && !in_err && (in_i.mode == LIST_A);
        cmd_b.push = in_acc && !in_err && (in_i.mode == LIST_B);
      end
      ST_ERR: begin
        load_en       = out_free;
        load_run_last = !can_emit;
        load_status   = err_code_q;
      end
      ST_CMP: begin
        load_en        = out_free;
        load_value     = (pick == LIST_B) ? rdata_b : rdata_a;
        load_list      = pick;
        load_run_last  = !can_next;
        load_mlast     = mlast;
        cmd_a.pop      = out_free && (pick == LIST_A);
        cmd_b.pop      = out_free && (pick == LIST_B);
        cmd_a.restart  = out_free && mlast;
        cmd_b.restart  = out_free && mlast;
      end
      default: begin
        load_en = 1'b0;
      end
    endcase
  end

  ssm_list_state #(.Depth(FIFO_DEPTH)) u_list_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .len_we_i (cfg_we && (cfg_i.index == REG_LENGTH_A)),
    .len_i    (cfg_i.data),
    .cmd_i    (cmd_a),
    .head_o   (head_a),
    .tail_o   (tail_a),
    .stat_o   (stat_a)
  );

  ssm_list_state #(.Depth(FIFO_DEPTH)) u_list_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .len_we_i (cfg_we && (cfg_i.index == REG_LENGTH_B)),
    .len_i    (cfg_i.data),
    .cmd_i    (cmd_b),
    .head_o   (head_b),
    .tail_o   (tail_b),
    .stat_o   (stat_b)
  );

  // The read ports always follow the heads; a write lands in the RAM before
  // the read state reads it, so no forwarding is needed.
  ssm_ram #(.Width(DataW), .Depth(FIFO_DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (cmd_a.push),
    .waddr_i (tail_a),
    .wdata_i (in_i.value),
    .raddr_i (head_a),
    .rdata_o (rdata_a)
  );

  ssm_ram #(.Width(DataW), .Depth(FIFO_DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (cmd_b.push),
    .waddr_i (tail_b),
    .wdata_i (in_i.value),
    .raddr_i (head_b),
    .rdata_o (rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_en) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      err_code_q <= in_code;
      err_mode_q <= in_i.mode;
    end
    if (load_en) begin
      out_value_q    <= load_value;
      out_list_q     <= load_list;
      out_run_last_q <= load_run_last;
      out_mlast_q    <= load_mlast;
      out_status_q   <= load_status;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.merged_value = out_value_q;
  assign out_o.from_list    = out_list_q;
  assign out_o.run_last     = out_run_last_q;
  assign out_o.merge_last   = out_mlast_q;
  assign out_o.status       = out_status_q;

  `SSM_ASSERT_NOW(a_err_result_clean, out_valid_q && (out_status_q != STATUS_OK), (out_value_q == '0) && !out_mlast_q, "drop report carries data or job end")
  `SSM_ASSERT_NOW(a_mlast_is_run_last, out_valid_q && out_mlast_q, out_run_last_q, "job end not marked as last result of its request")
  `SSM_ASSERT_NOW(a_cmp_has_data, state_q == ST_CMP, stat_a.nonempty || stat_b.nonempty, "compare state with both FIFOs empty")
  `SSM_ASSERT_NEXT(a_last_to_idle, load_en && load_run_last, state_q == ST_IDLE, "sequencer kept working after the last result")

endmodule

`default_nettype wire

// ===== tb/sv/merge_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merge_checker
// Watches the register, element and result channels of sorted_stream_merge.
// It keeps its own copy of both list FIFOs and receive counts, works out the
// results of every element request, and compares each result request with
// the oldest one still expected.
// ----------------------------------------------------------------------------
module merge_checker import ssm_pkg::*; #(
  parameter int unsigned FifoDepth = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssm_cfg_if          cfg_mon_i,
  ssm_in_if           in_mon_i,
  ssm_out_if          out_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned PtrW        = $clog2(FifoDepth);
  localparam int unsigned CntW        = $clog2(FifoDepth + 1);
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    list;
    logic                    run_last;
    logic                    merge_last;
    status_e                 status;
  } merge_result_t;

  merge_result_t           merged_q [$];
  logic signed [DataW-1:0] list_mem [2][FifoDepth];
  logic [PtrW-1:0]         rd_ptr   [2];
  logic [CntW-1:0]         fill     [2];
  logic [LenW-1:0]         received [2];
  logic [LenW-1:0]         list_len [2];

  task automatic note_result(input logic signed [DataW-1:0] value, input logic list,
                             input logic merge_last, input status_e status);
    merge_result_t r;
    r.value      = value;
    r.list       = list;
    r.run_last   = 1'b0;
    r.merge_last = merge_last;
    r.status     = status;
    merged_q.push_back(r);
  endtask

  // One element request: store or drop it, then emit heads while a choice exists.
  task automatic predict_merge(input logic list, input logic signed [DataW-1:0] elem);
    logic                    pick;
    logic                    done_a;
    logic                    done_b;
    logic signed [DataW-1:0] head_val;
    int unsigned             first;
    int unsigned             wr_idx;
    first = merged_q.size();
    if (received[list] >= list_len[list]) begin
      note_result('0, list, 1'b0, STATUS_DONE);
    end else if (fill[list] == CntW'(FifoDepth)) begin
      note_result('0, list, 1'b0, STATUS_FULL);
    end else begin
      wr_idx = (int'(rd_ptr[list]) + int'(fill[list])) % FifoDepth;
      list_mem[list][wr_idx] = elem;
      fill[list] = fill[list] + 1'b1;
      received[list] = received[list] + 1'b1;
    end
    forever begin
      done_a = received[LIST_A] >= list_len[LIST_A];
      done_b = received[LIST_B] >= list_len[LIST_B];
      if (fill[LIST_A] != 0 && fill[LIST_B] != 0) begin
        pick = (list_mem[LIST_A][rd_ptr[LIST_A]] <= list_mem[LIST_B][rd_ptr[LIST_B]]) ?
               LIST_A : LIST_B;
      end else if (fill[LIST_A] != 0 && done_b) begin
        pick = LIST_A;
      end else if (fill[LIST_B] != 0 && done_a) begin
        pick = LIST_B;
      end else begin
        break;
      end
      head_val = list_mem[pick][rd_ptr[pick]];
      rd_ptr[pick] = (rd_ptr[pick] == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr[pick] + 1'b1;
      fill[pick] = fill[pick] - 1'b1;
      if (done_a && done_b && fill[LIST_A] == 0 && fill[LIST_B] == 0) begin
        received[LIST_A] = '0;
        received[LIST_B] = '0;
        note_result(head_val, pick, 1'b1, STATUS_OK);
      end else begin
        note_result(head_val, pick, 1'b0, STATUS_OK);
      end
    end
    if (merged_q.size() > first) begin
      merged_q[merged_q.size() - 1].run_last = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    merge_result_t got;
    merge_result_t want;
    if (!rst_ni) begin
      merged_q.delete();
      for (int i = 0; i < 2; i++) begin
        rd_ptr[i]   = '0;
        fill[i]     = '0;
        received[i] = '0;
        list_len[i] = LenW'(1);
      end
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // A result can never belong to the element taken at the same edge.
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.value      = out_mon_i.merged_value;
        got.list       = out_mon_i.from_list;
        got.run_last   = out_mon_i.run_last;
        got.merge_last = out_mon_i.merge_last;
        got.status     = status_e'(out_mon_i.status);
        if (merged_q.size() == 0) begin
          if (fail_count_o < ReportLimit) begin
            $display("[%0t] unexpected result: value %0d list %0b run_last %0b",
                     $realtime, got.value, got.list, got.run_last,
                     " merge_last %0b status %0d", got.merge_last, got.status);
          end
          fail_count_o++;
        end else begin
          want = merged_q.pop_front();
          if (got !== want) begin
            if (fail_count_o < ReportLimit) begin
              $display("[%0t] result mismatch: expected value %0d list %0b run_last %0b",
                       $realtime, want.value, want.list, want.run_last,
                       " merge_last %0b status %0d", want.merge_last, want.status);
              $display("                     got value %0d list %0b run_last %0b",
                       got.value, got.list, got.run_last,
                       " merge_last %0b status %0d", got.merge_last, got.status);
            end
            fail_count_o++;
          end
        end
      end
      if (cfg_mon_i.valid && cfg_mon_i.ready) begin
        case (cfg_mon_i.index)
          REG_LENGTH_A: list_len[LIST_A] = cfg_mon_i.data;
          REG_LENGTH_B: list_len[LIST_B] = cfg_mon_i.data;
          default: ;
        endcase
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        predict_merge(in_mon_i.mode, in_mon_i.value);
      end
      pending_o = merged_q.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for sorted_stream_merge. A short directed part covers the value
// extremes, ties, drops and list lengths changed or set to zero; then come
// an overflow scenario and random merge jobs of ascending lists with stray
// and out-of-order elements, with random gaps and result stalls.
// ----------------------------------------------------------------------------
module tb;
  import ssm_pkg::*;

  localparam int unsigned     FifoDepth    = 32;
  localparam int unsigned     RandomItems  = 100;
  localparam int unsigned     CalmAfter    = 80;
  localparam int unsigned     SettleCycles = 8;
  localparam int unsigned     LimitCycles  = 200000;
  localparam logic [LenW-1:0] MaxLen       = '1;
  localparam longint          MaxVal       = 64'sd2147483647;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned sent_items  = 0;
  int unsigned random_start;
  int unsigned gap_pct     = 20;
  int unsigned stall_pct   = 20;
  bit          calm        = 1'b0;

  ssm_cfg_if cfg_ch ();
  ssm_in_if  in_ch ();
  ssm_out_if out_ch ();

  sorted_stream_merge #(
    .FIFO_DEPTH(FifoDepth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  merge_checker #(
    .FifoDepth(FifoDepth)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_mon_i   (cfg_ch),
    .in_mon_i    (in_ch),
    .out_mon_i   (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LimitCycles) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side stalls in bursts.
  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // All tasks start and end at a falling edge with nothing yet driven in that step.
  task automatic set_lengths(input logic [LenW-1:0] len_a, input logic [LenW-1:0] len_b);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_LENGTH_A;
    cfg_ch.data  <= len_a;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.index <= REG_LENGTH_B;
    cfg_ch.data  <= len_b;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_element(input logic list, input logic signed [DataW-1:0] elem);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= list;
    in_ch.value <= elem;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    sent_items++;
  endtask

  // An element with no result may still be in flight when nothing is pending.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // One merge job: two ascending lists sent in some interleaving, with the
  // odd out-of-order value and the odd stray element for a finished list.
  task automatic run_job(input logic [LenW-1:0] len_a, input logic [LenW-1:0] len_b);
    longint                  nxt  [2];
    int unsigned             left [2];
    logic                    l;
    logic signed [DataW-1:0] elem;
    int unsigned             order;
    bit                      wide;
    wait_drained();
    set_lengths(len_a, len_b);
    gap_pct   = 10 * $urandom_range(0, 3);
    stall_pct = 10 * $urandom_range(0, 3);
    order     = $urandom_range(0, 3);
    wide      = $urandom_range(0, 2) != 0;
    for (int i = 0; i < 2; i++) begin
      nxt[i] = wide ? longint'($signed($urandom)) : longint'($urandom_range(0, 6)) - 3;
    end
    left[LIST_A] = 32'(len_a);
    left[LIST_B] = 32'(len_b);
    while (left[LIST_A] + left[LIST_B] != 0) begin
      if (left[LIST_A] == 0) begin
        l = LIST_B;
      end else if (left[LIST_B] == 0) begin
        l = LIST_A;
      end else if (order == 2) begin
        l = LIST_A;
      end else if (order == 3) begin
        l = LIST_B;
      end else begin
        l = 1'($urandom_range(0, 1));
      end
      if ((left[LIST_A] == 0 || left[LIST_B] == 0) && $urandom_range(0, 99) < 6) begin
        send_element(~l, $urandom);
      end
      elem = ($urandom_range(0, 99) < 4) ? $urandom : DataW'(nxt[l]);
      send_element(l, elem);
      left[l]--;
      nxt[l] += wide ? longint'($urandom_range(0, 32'h1000_0000)) :
                       longint'($urandom_range(0, 2));
      if (nxt[l] > MaxVal) begin
        nxt[l] = MaxVal;
      end
      if ($urandom_range(0, 99) < 3) begin
        wait_drained();
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = LIST_A;
    in_ch.value  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_LENGTH_A;
    cfg_ch.data  = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Lengths of one after reset; the value range extremes.
    send_element(LIST_A, 32'sh8000_0000);
    send_element(LIST_B, 32'sh7fff_ffff);

    // Ties go to list A; a stray element for a complete list is dropped.
    wait_drained();
    set_lengths(LenW'(2), LenW'(2));
    send_element(LIST_A, 5);
    send_element(LIST_B, 5);
    send_element(LIST_B, 7);
    send_element(LIST_B, -1);
    send_element(LIST_A, 7);

    // A register write completes list A mid-job; the next element is
    // dropped and list B drains behind the drop report.
    wait_drained();
    set_lengths(LenW'(3), LenW'(1));
    send_element(LIST_A, 10);
    send_element(LIST_A, 20);
    send_element(LIST_B, 30);
    wait_drained();
    set_lengths(LenW'(2), LenW'(1));
    send_element(LIST_A, 40);

    // A zero-length list is complete from the start.
    wait_drained();
    set_lengths(LenW'(0), LenW'(2));
    send_element(LIST_B, -3);
    send_element(LIST_B, 4);
    send_element(LIST_A, 1);

    random_start = sent_items;

    // Fill FIFO A past its depth, then release it all in one request.
    wait_drained();
    set_lengths(MaxLen, LenW'(1));
    repeat (FifoDepth + 1) send_element(LIST_A, $urandom);
    wait_drained();
    set_lengths(MaxLen, LenW'(0));
    send_element(LIST_A, $urandom);
    wait_drained();
    set_lengths(LenW'(FifoDepth + 1), LenW'(0));
    send_element(LIST_A, $urandom);

    while (sent_items - random_start < RandomItems) begin
      if (sent_items - random_start >= CalmAfter) begin
        calm = 1'b1;
      end
      if ($urandom_range(0, 4) == 0) begin
        run_job(LenW'($urandom_range(9, 32)), LenW'($urandom_range(1, 32)));
      end else begin
        run_job(LenW'($urandom_range(1, 8)), LenW'($urandom_range(1, 8)));
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
